@@ src/vchp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vchp_pkg
// Shared types and constants of the video controller host port.
// ----------------------------------------------------------------------------
package vchp_pkg;

  localparam int VCHP_VRAM_WORDS = 32768;
  localparam int MAX_SHOWN_LINES = 242;
  localparam int ACTIVE_START_LINE = 14;

  localparam int NUM_REGS = 20;
  localparam int SEL_W = 5;
  localparam int STAT_W = 7;

  // Request types.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // Port numbers.
  localparam logic [1:0] PORT_SEL = 2'd0;
  localparam logic [1:0] PORT_LO = 2'd2;
  localparam logic [1:0] PORT_HI = 2'd3;

  // Register numbers.
  localparam logic [SEL_W-1:0] R_WADDR = 5'd0;
  localparam logic [SEL_W-1:0] R_RADDR = 5'd1;
  localparam logic [SEL_W-1:0] R_DATA = 5'd2;
  localparam logic [SEL_W-1:0] R_CTRL = 5'd5;
  localparam logic [SEL_W-1:0] R_RCMP = 5'd6;
  localparam logic [SEL_W-1:0] R_VDW = 5'd13;

  // Status flag positions.
  localparam int F_COLL = 0;
  localparam int F_OVER = 1;
  localparam int F_RAST = 2;
  localparam int F_DONE = 3;
  localparam int F_VBL = 5;
  localparam int F_BUSY = 6;

  localparam logic [10:0] RASTER_OFFSET = 11'h040;

  localparam logic [15:0] STEP_TABLE [4] = '{16'd1, 16'd32, 16'd64, 16'd128};

  localparam logic [15:0] REG_RESET [NUM_REGS] = '{
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
    16'h0202, 16'h041F, 16'h0F02, 16'h00EF, 16'h0003,
    16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
  };

  // Video memory requests from the register logic to the memory.
  typedef struct packed {
    logic        wr_en;
    logic [15:0] wr_addr;
    logic [15:0] wr_data;
    logic        rd_en;
    logic [15:0] rd_addr;
  } vchp_mem_req_t;

endpackage
`default_nettype wire

@@ src/vchp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vchp_in_if / vchp_out_if
// Valid/ready channels for host requests and their results.
// ----------------------------------------------------------------------------
interface vchp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [1:0] port;
  logic [7:0] wdata;
  logic [9:0] line;

  modport source(output valid, req_type, port, wdata, line, input ready);
  modport sink(input valid, req_type, port, wdata, line, output ready);
endinterface

interface vchp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       irq;

  modport source(output valid, rdata, irq, input ready);
  modport sink(input valid, rdata, irq, output ready);
endinterface
`default_nettype wire

@@ src/video_controller_host_port.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// video_controller_host_port
// Host side of a tile video controller: register file, video memory access
// and status flags with interrupt level.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one host request per item: a port write, a port read or a
//   line tick. out_ch returns exactly one item per request with the byte
//   read (zero for anything but a port read) and the irq level after it.
//   Every request is registered when it is taken; its result sits in the output
//   register from the next cycle on, and a new item is accepted every cycle
//   while in_ch.ready is high. Video memory is one single-port-write array
//   with a registered read that doubles as the read buffer; a read-address
//   write or data read loads it at the accepting edge.
//   After reset the memory is cleared, one word per cycle; in_ch.ready stays
//   low during that pass.
//   While out_ch.ready is low and a result is held, in_ch.ready is low too;
//   it rises again in the cycle the held result is taken.
// ----------------------------------------------------------------------------
module video_controller_host_port
  import vchp_pkg::*;
#(
  parameter int VRAM_WORDS = VCHP_VRAM_WORDS
) (
  input wire logic   clk,
  input wire logic   rst_n,
  vchp_in_if.sink    in_ch,
  vchp_out_if.source out_ch
);

  logic [15:0]       reg_file_r [NUM_REGS];
  logic [SEL_W-1:0]  sel_r, sel_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [7:0]        low_latch_r, low_latch_nxt;
  logic              low_valid_r, low_valid_nxt;
  logic              out_valid_r;
  logic [7:0]        out_rdata_r, out_rdata_nxt;
  logic              out_irq_r, out_irq_nxt;

  vchp_mem_req_t     mreq;
  logic              mem_ready;
  logic [15:0]       read_buffer;

  logic              accept;
  logic              sel_ok;
  logic [15:0]       step;
  logic [15:0]       ctrl_after;
  logic [15:0]       data_word;
  logic [15:0]       wr_word;
  logic              we_a, we_b;
  logic [SEL_W-1:0]  idx_a, idx_b;
  logic [15:0]       val_a, val_b;
  logic [9:0]        vis_lines, vis_capped;
  logic [10:0]       vbl_line;
  logic [9:0]        rcmp;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = mem_ready && (!out_valid_r || out_ch.ready);

  assign sel_ok = (sel_r < SEL_W'(NUM_REGS));
  assign step = STEP_TABLE[reg_file_r[R_CTRL][12:11]];
  assign data_word = (sel_r == R_DATA) ? read_buffer :
                     (sel_ok ? reg_file_r[sel_r] : 16'd0);
  assign wr_word = {in_ch.wdata, (low_valid_r ? low_latch_r : 8'd0)};

  // Line where vblank starts: visible height capped at the display maximum.
  assign vis_lines = {1'b0, reg_file_r[R_VDW][8:0]} + 10'd1;
  assign vis_capped = (vis_lines > 10'(MAX_SHOWN_LINES)) ? 10'(MAX_SHOWN_LINES) : vis_lines;
  assign vbl_line = 11'(ACTIVE_START_LINE) + {1'b0, vis_capped};
  assign rcmp = reg_file_r[R_RCMP][9:0];

  always_comb begin
    sel_nxt = sel_r;
    status_nxt = status_r;
    low_latch_nxt = low_latch_r;
    low_valid_nxt = low_valid_r;
    out_rdata_nxt = 8'd0;
    we_a = 1'b0;
    idx_a = sel_r;
    val_a = wr_word;
    we_b = 1'b0;
    idx_b = R_WADDR;
    val_b = reg_file_r[R_WADDR] + step;
    mreq = '0;
    mreq.wr_addr = reg_file_r[R_WADDR];
    mreq.wr_data = wr_word;
    mreq.rd_addr = reg_file_r[R_RADDR];

    case (in_ch.req_type)
      REQ_WRITE: begin
        case (in_ch.port)
          PORT_SEL: begin
            sel_nxt = in_ch.wdata[SEL_W-1:0];
            low_valid_nxt = 1'b0;
          end
          PORT_LO: begin
            low_latch_nxt = in_ch.wdata;
            low_valid_nxt = 1'b1;
          end
          PORT_HI: begin
            low_valid_nxt = 1'b0;
            if (sel_ok) begin
              we_a = 1'b1;
              if (sel_r == R_DATA) begin
                mreq.wr_en = 1'b1;
                we_b = 1'b1;
              end else if (sel_r == R_RADDR) begin
                // The new read address prefetches and then steps.
                mreq.rd_en = 1'b1;
                mreq.rd_addr = wr_word;
                val_a = wr_word + step;
              end
            end
          end
          default: begin
          end
        endcase
      end
      REQ_READ: begin
        case (in_ch.port)
          PORT_SEL: begin
            out_rdata_nxt = 8'(status_r);
            status_nxt = status_r & STAT_W'(1 << F_BUSY);
          end
          PORT_LO: begin
            out_rdata_nxt = data_word[7:0];
            low_latch_nxt = data_word[7:0];
          end
          PORT_HI: begin
            out_rdata_nxt = data_word[15:8];
          end
          default: begin
          end
        endcase
        if ((in_ch.port inside {PORT_LO, PORT_HI}) && sel_r == R_DATA) begin
          mreq.rd_en = 1'b1;
          we_a = 1'b1;
          idx_a = R_RADDR;
          val_a = reg_file_r[R_RADDR] + step;
        end
      end
      REQ_TICK: begin
        status_nxt[F_RAST] = 1'b0;
        if (in_ch.line == 10'(ACTIVE_START_LINE)) begin
          status_nxt[F_VBL] = 1'b0;
        end
        if (rcmp != 10'd0 && {1'b0, rcmp} == ({1'b0, in_ch.line} + RASTER_OFFSET)) begin
          status_nxt[F_RAST] = 1'b1;
        end
        if ({1'b0, in_ch.line} == vbl_line) begin
          status_nxt[F_VBL] = 1'b1;
          status_nxt[F_DONE] = 1'b1;
        end
      end
      default: begin
      end
    endcase

    ctrl_after = (we_a && idx_a == R_CTRL) ? val_a : reg_file_r[R_CTRL];
    out_irq_nxt = (status_nxt[F_VBL] && ctrl_after[3]) ||
                  (status_nxt[F_RAST] && ctrl_after[2]) ||
                  (status_nxt[F_OVER] && ctrl_after[0]) ||
                  (status_nxt[F_COLL] && ctrl_after[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        reg_file_r[i] <= REG_RESET[i];
      end
      sel_r <= '0;
      status_r <= '0;
      low_latch_r <= '0;
      low_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        sel_r <= sel_nxt;
        status_r <= status_nxt;
        low_latch_r <= low_latch_nxt;
        low_valid_r <= low_valid_nxt;
        if (we_a) begin
          reg_file_r[idx_a] <= val_a;
        end
        if (we_b) begin
          reg_file_r[idx_b] <= val_b;
        end
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_rdata_r <= out_rdata_nxt;
      out_irq_r <= out_irq_nxt;
    end
  end

  vchp_vram #(
    .VRAM_WORDS(VRAM_WORDS)
  ) u_vram (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (accept ? mreq : vchp_mem_req_t'('0)),
    .ready  (mem_ready),
    .rd_data(read_buffer)
  );

  assign out_ch.valid = out_valid_r;
  assign out_ch.rdata = out_rdata_r;
  assign out_ch.irq = out_irq_r;

endmodule
`default_nettype wire

@@ src/vchp_vram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vchp_vram
// Video memory with one write and one registered read port. After reset a
// clearing pass zeroes every word, one per cycle, before ready rises.
// ----------------------------------------------------------------------------
module vchp_vram
  import vchp_pkg::*;
#(
  parameter int VRAM_WORDS = VCHP_VRAM_WORDS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire vchp_mem_req_t req,
  output logic               ready,
  output logic [15:0]        rd_data
);

  localparam int AW = $clog2(VRAM_WORDS);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } vram_state_t;

  vram_state_t       state_r, state_nxt;
  logic [AW-1:0]     clr_idx_r, clr_idx_nxt;
  logic [15:0]       rd_data_r;
  logic [AW-1:0]     wr_idx, rd_idx;
  logic [15:0]       mem [VRAM_WORDS];

  // Address modulo the memory size: seven conditional subtractions of scaled
  // sizes suffice while the quotient stays below 128.
  function automatic logic [AW-1:0] wrap_addr(input logic [15:0] a);
    logic [16:0] v;
    logic [22:0] lim;
    begin
      v = {1'b0, a};
      for (int k = 6; k >= 0; k--) begin
        lim = 23'(VRAM_WORDS) << k;
        if ({6'd0, v} >= lim) begin
          v = v - 17'(lim);
        end
      end
      return AW'(v);
    end
  endfunction

  assign wr_idx = wrap_addr(req.wr_addr);
  assign rd_idx = wrap_addr(req.rd_addr);

  always_comb begin
    state_nxt = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(VRAM_WORDS - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      mem[clr_idx_r] <= '0;
    end else if (req.wr_en) begin
      mem[wr_idx] <= req.wr_data;
    end
  end

  // The read register is the host's read buffer, so it resets to zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_data_r <= '0;
    end else if (req.rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign ready = (state_r == ST_RUN);
  assign rd_data = rd_data_r;

`ifndef SYNTHESIS
  a_no_access_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!req.wr_en && !req.rd_en))
    else $error("video memory accessed during clearing pass");

  a_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |=> (state_r == ST_RUN))
    else $error("video memory left run state without reset");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (req.wr_en || req.rd_en) |->
      ({1'b0, wr_idx} < 17'(VRAM_WORDS) && {1'b0, rd_idx} < 17'(VRAM_WORDS)))
    else $error("wrapped video memory index out of range");
`endif

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the video controller host port. Port accesses and
// line ticks go in through a valid/ready channel. A shadow copy of the
// register file, video memory and status flags computes the expected byte
// and irq level of every accepted item, and each returned item is checked
// against them in order. Both sides of the block idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import vchp_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [1:0] PORT_NONE = 2'd1;
  localparam int N_ITEMS = 1200;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_AT = 600;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 150;
  localparam logic [SEL_W-1:0] HOT_REGS [6] = '{R_WADDR, R_RADDR, R_DATA, R_CTRL, R_RCMP,
                                                R_VDW};

  typedef struct packed {
    logic [1:0] req_type;
    logic [1:0] port;
    logic [7:0] wdata;
    logic [9:0] line;
    logic       drain;
  } host_req_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
  } host_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic       drv_valid = 1'b0;
  logic [1:0] drv_req_type = REQ_WRITE;
  logic [1:0] drv_port = PORT_SEL;
  logic [7:0] drv_wdata = 8'h00;
  logic [9:0] drv_line = 10'h000;
  logic       rsp_ready = 1'b0;

  vchp_in_if in_ch ();
  vchp_out_if out_ch ();

  assign in_ch.valid = drv_valid;
  assign in_ch.req_type = drv_req_type;
  assign in_ch.port = drv_port;
  assign in_ch.wdata = drv_wdata;
  assign in_ch.line = drv_line;
  assign out_ch.ready = rsp_ready;

  video_controller_host_port dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  host_req_t  pending_reqs[$];
  host_resp_t expected_resps[$];
  int unsigned n_stim = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;
  logic calm;

  // Neither side idles while this window of items goes through.
  assign calm = (n_accepted >= 800) && (n_accepted < 1000);

  // --------------------------------------------------------------------------
  // Shadow state of the block
  // --------------------------------------------------------------------------
  logic [15:0]       shadow_regs [NUM_REGS];
  logic [15:0]       shadow_vram [VCHP_VRAM_WORDS];
  logic [SEL_W-1:0]  shadow_sel;
  logic [STAT_W-1:0] shadow_flags;
  logic [15:0]       shadow_rbuf;
  logic [7:0]        shadow_low;
  logic              shadow_low_ok;

  function automatic logic [15:0] addr_step();
    return STEP_TABLE[shadow_regs[R_CTRL][12:11]];
  endfunction

  task automatic refill_read_buffer();
    shadow_rbuf = shadow_vram[int'(shadow_regs[R_RADDR]) % VCHP_VRAM_WORDS];
    shadow_regs[R_RADDR] = shadow_regs[R_RADDR] + addr_step();
  endtask

  // Reading the data register hands out the buffered word and refetches.
  task automatic read_data_word(output logic [15:0] w);
    if (shadow_sel == R_DATA) begin
      w = shadow_rbuf;
      refill_read_buffer();
    end else begin
      w = (shadow_sel < NUM_REGS) ? shadow_regs[shadow_sel] : 16'h0000;
    end
  endtask

  task automatic apply_request(input host_req_t r, output host_resp_t o);
    logic [15:0] w;
    logic [7:0] rd;
    logic [15:0] ctrl;
    int h;
    int rc;
    rd = 8'h00;
    case (r.req_type)
      REQ_WRITE: begin
        case (r.port)
          PORT_SEL: begin
            shadow_sel = r.wdata[SEL_W-1:0];
            shadow_low_ok = 1'b0;
          end
          PORT_LO: begin
            shadow_low = r.wdata;
            shadow_low_ok = 1'b1;
          end
          PORT_HI: begin
            w = {r.wdata, shadow_low_ok ? shadow_low : 8'h00};
            shadow_low_ok = 1'b0;
            if (shadow_sel < NUM_REGS) begin
              shadow_regs[shadow_sel] = w;
              if (shadow_sel == R_DATA) begin
                shadow_vram[int'(shadow_regs[R_WADDR]) % VCHP_VRAM_WORDS] = w;
                shadow_regs[R_WADDR] = shadow_regs[R_WADDR] + addr_step();
              end else if (shadow_sel == R_RADDR) begin
                refill_read_buffer();
              end
            end
          end
          default: ;
        endcase
      end
      REQ_READ: begin
        case (r.port)
          PORT_SEL: begin
            rd = {1'b0, shadow_flags};
            shadow_flags = shadow_flags & STAT_W'(1 << F_BUSY);
          end
          PORT_LO: begin
            read_data_word(w);
            shadow_low = w[7:0];
            rd = w[7:0];
          end
          PORT_HI: begin
            read_data_word(w);
            rd = w[15:8];
          end
          default: ;
        endcase
      end
      REQ_TICK: begin
        h = int'(shadow_regs[R_VDW][8:0]) + 1;
        if (h > MAX_SHOWN_LINES) h = MAX_SHOWN_LINES;
        rc = int'(shadow_regs[R_RCMP][9:0]);
        shadow_flags[F_RAST] = 1'b0;
        if (int'(r.line) == ACTIVE_START_LINE) shadow_flags[F_VBL] = 1'b0;
        // The compare sum does not wrap, so the last lines never match.
        if (rc != 0 && rc == int'(r.line) + int'(RASTER_OFFSET)) shadow_flags[F_RAST] = 1'b1;
        if (int'(r.line) == ACTIVE_START_LINE + h) begin
          shadow_flags[F_VBL] = 1'b1;
          shadow_flags[F_DONE] = 1'b1;
        end
      end
      default: ;
    endcase
    ctrl = shadow_regs[R_CTRL];
    o.rdata = rd;
    o.irq = (shadow_flags[F_VBL] & ctrl[3]) | (shadow_flags[F_RAST] & ctrl[2]) |
            (shadow_flags[F_OVER] & ctrl[0]) | (shadow_flags[F_COLL] & ctrl[1]);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  logic [15:0] gen_vdw = REG_RESET[R_VDW];
  logic [15:0] gen_rcr = REG_RESET[R_RCMP];

  task automatic push_req(input logic [1:0] t, input logic [1:0] p, input logic [7:0] d,
                          input logic [9:0] ln);
    host_req_t r;
    r.req_type = t;
    r.port = p;
    r.wdata = d;
    r.line = ln;
    r.drain = (pending_reqs.size() == DRAIN_AT);
    pending_reqs.push_back(r);
    if (!(t == REQ_NONE || (t == REQ_WRITE && p == PORT_NONE))) n_stim++;
  endtask

  task automatic push_select(input logic [SEL_W-1:0] rn);
    push_req(REQ_WRITE, PORT_SEL, {3'($urandom), rn}, 10'($urandom));
  endtask

  // Without the low byte the block writes zero in its place.
  task automatic write_reg(input logic [SEL_W-1:0] rn, input logic [15:0] v, input bit with_low);
    logic [15:0] eff;
    eff = with_low ? v : {v[15:8], 8'h00};
    push_select(rn);
    if (with_low) push_req(REQ_WRITE, PORT_LO, v[7:0], 10'($urandom));
    push_req(REQ_WRITE, PORT_HI, v[15:8], 10'($urandom));
    if (rn == R_VDW) gen_vdw = eff;
    if (rn == R_RCMP) gen_rcr = eff;
  endtask

  function automatic logic [SEL_W-1:0] pick_reg();
    int k;
    k = $urandom_range(9);
    if (k < 6) return HOT_REGS[$urandom_range(5)];
    if (k < 9) return SEL_W'($urandom_range(NUM_REGS - 1));
    return SEL_W'($urandom_range(31, NUM_REGS));
  endfunction

  // Mostly a small window so reads find earlier writes; some near the wrap.
  function automatic logic [15:0] pick_addr();
    case ($urandom_range(5))
      0: return 16'($urandom);
      1: return 16'(VCHP_VRAM_WORDS - 16 + $urandom_range(31));
      default: return 16'($urandom_range(255));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    host_req_t r;
    host_resp_t resp;
    bit offer;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_ch.ready) begin
        r.req_type = drv_req_type;
        r.port = drv_port;
        r.wdata = drv_wdata;
        r.line = drv_line;
        r.drain = 1'b0;
        apply_request(r, resp);
        expected_resps.push_back(resp);
        n_accepted++;
      end
      if (!drv_valid || in_ch.ready) begin
        offer = (pending_reqs.size() > 0) && (calm || $urandom_range(99) >= 12);
        // A marked item waits until every earlier result has come back.
        if (offer && pending_reqs[0].drain && expected_resps.size() > 0) offer = 1'b0;
        if (offer) begin
          r = pending_reqs.pop_front();
          drv_req_type <= r.req_type;
          drv_port <= r.port;
          drv_wdata <= r.wdata;
          drv_line <= r.line;
        end
        drv_valid <= offer;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------
  int unsigned holdoff_left = 0;
  bit held = 1'b0;

  always @(posedge clk) begin : accept_results
    if (!rst_n) begin
      rsp_ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      rsp_ready <= 1'b0;
    end else if (!held && n_results >= HOLD_AT) begin
      // Long stall so the block backs up into its input channel.
      held = 1'b1;
      holdoff_left = HOLD_CYCLES;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= calm || ($urandom_range(99) >= 12);
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    n_errors++;
    if (n_errors <= 100)
      $display("[%0t] result %0d: %s is 0x%0h, expected 0x%0h", $time, n_results, what, got,
               want);
  endtask

  always @(posedge clk) begin : check_results
    host_resp_t want;
    if (rst_n && out_ch.valid && rsp_ready) begin
      n_results++;
      if (expected_resps.size() == 0) begin
        report_mismatch("rdata of an item with no request waiting", out_ch.rdata, 0);
      end else begin
        want = expected_resps.pop_front();
        if (out_ch.rdata !== want.rdata) report_mismatch("rdata", out_ch.rdata, want.rdata);
        if (out_ch.irq !== want.irq) report_mismatch("irq", out_ch.irq, want.irq);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    n_cycles++;
    if (n_cycles >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int kind;
    int h;
    int last_line;
    int rl;
    logic [15:0] v;
    logic [9:0] ln;

    foreach (shadow_regs[i]) shadow_regs[i] = REG_RESET[i];
    foreach (shadow_vram[i]) shadow_vram[i] = 16'h0000;
    shadow_sel = '0;
    shadow_flags = '0;
    shadow_rbuf = 16'h0000;
    shadow_low = 8'h00;
    shadow_low_ok = 1'b0;

    // Directed part.
    push_req(REQ_READ, PORT_SEL, 8'h00, 10'h000);
    push_req(REQ_READ, PORT_NONE, 8'hFF, 10'h3FF);
    push_req(REQ_NONE, PORT_HI, 8'hFF, 10'h3FF);
    write_reg(R_CTRL, 16'h180F, 1'b1);
    write_reg(R_WADDR, 16'hFFFF, 1'b0);
    write_reg(R_DATA, 16'hFFFF, 1'b1);
    write_reg(R_RADDR, 16'hFF00, 1'b1);
    push_select(R_DATA);
    push_req(REQ_READ, PORT_HI, 8'h00, 10'h000);
    push_req(REQ_READ, PORT_LO, 8'h00, 10'h000);
    // A data read overwrites the latched low byte but keeps it valid.
    push_req(REQ_WRITE, PORT_LO, 8'h12, 10'h000);
    push_req(REQ_READ, PORT_LO, 8'h00, 10'h000);
    push_req(REQ_WRITE, PORT_HI, 8'h34, 10'h000);
    write_reg(R_RCMP, 16'h0050, 1'b1);
    push_req(REQ_TICK, PORT_SEL, 8'h00, 10'h010);
    push_req(REQ_TICK, PORT_SEL, 8'h00, 10'(ACTIVE_START_LINE));
    push_req(REQ_TICK, PORT_SEL, 8'h00, 10'(ACTIVE_START_LINE + 240));
    push_req(REQ_READ, PORT_SEL, 8'h00, 10'h000);
    write_reg(5'd31, 16'hABCD, 1'b0);

    // Random part: mostly well-formed access sequences, some noise.
    while (n_stim < N_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 18) begin
        write_reg(pick_reg(), 16'($urandom), $urandom_range(9) < 8);
      end else if (kind < 36) begin
        write_reg(R_WADDR, pick_addr(), 1'b1);
        push_select(R_DATA);
        repeat ($urandom_range(6, 1)) begin
          if ($urandom_range(9) < 8) push_req(REQ_WRITE, PORT_LO, 8'($urandom), 10'($urandom));
          push_req(REQ_WRITE, PORT_HI, 8'($urandom), 10'($urandom));
        end
      end else if (kind < 52) begin
        write_reg(R_RADDR, pick_addr(), 1'b1);
        push_select(R_DATA);
        repeat ($urandom_range(6, 1))
          push_req(REQ_READ, $urandom_range(1) ? PORT_LO : PORT_HI, 8'($urandom),
                   10'($urandom));
      end else if (kind < 60) begin
        push_select(pick_reg());
        repeat ($urandom_range(3, 1))
          push_req(REQ_READ, 2'($urandom), 8'($urandom), 10'($urandom));
      end else if (kind < 80) begin
        if ($urandom_range(1)) begin
          v = 16'($urandom);
          if ($urandom_range(1)) v[8:0] = 9'($urandom_range(40));
          write_reg(R_VDW, v, 1'b1);
        end
        if ($urandom_range(1)) begin
          v = 16'($urandom);
          if ($urandom_range(3) != 0)
            v[9:0] = 10'($urandom_range(10'h3BF) + int'(RASTER_OFFSET));
          write_reg(R_RCMP, v, 1'b1);
        end
        h = int'(gen_vdw[8:0]) + 1;
        if (h > MAX_SHOWN_LINES) h = MAX_SHOWN_LINES;
        last_line = ACTIVE_START_LINE + h;
        rl = int'(gen_rcr[9:0]) - int'(RASTER_OFFSET);
        repeat ($urandom_range(6, 1)) begin
          case ($urandom_range(7))
            0: ln = 10'(ACTIVE_START_LINE);
            1, 2: ln = 10'(last_line);
            3: ln = 10'(last_line + int'($urandom_range(2)) - 1);
            4, 5: ln = (rl >= 0) ? 10'(rl) : 10'h3BF;
            6: ln = $urandom_range(1) ? 10'h3FF : 10'h3BF;
            default: ln = 10'($urandom);
          endcase
          push_req(REQ_TICK, 2'($urandom), 8'($urandom), ln);
        end
        if ($urandom_range(1)) push_req(REQ_READ, PORT_SEL, 8'($urandom), 10'($urandom));
      end else if (kind < 88) begin
        write_reg(R_CTRL, 16'($urandom), 1'b1);
        push_req(REQ_READ, PORT_SEL, 8'($urandom), 10'($urandom));
      end else begin
        repeat ($urandom_range(4, 1))
          push_req(2'($urandom), 2'($urandom), 8'($urandom), 10'($urandom));
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() > 0 || drv_valid) @(posedge clk);
    while (expected_resps.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
